@@ sv/utf8d_pkg.sv @@
// Shared types and constants for the UTF-8 decoder.
// No dependencies; used by utf8d_decode and utf8_decoder_with_replacement.
`default_nettype none

package utf8d_pkg;

	localparam int CP_W = 21;

	localparam logic [CP_W-1:0] REPL_CP    = 21'h00FFFD;
	localparam logic [CP_W-1:0] MAX_SCALAR = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] MIN_LEN2   = 21'h000080;
	localparam logic [CP_W-1:0] MIN_LEN3   = 21'h000800;
	localparam logic [CP_W-1:0] MIN_LEN4   = 21'h010000;

	localparam logic [2:0] LEN_NONE = 3'd0;
	localparam logic [2:0] LEN_2    = 3'd2;
	localparam logic [2:0] LEN_3    = 3'd3;
	localparam logic [2:0] LEN_4    = 3'd4;

	// Results caused by one byte: n_repl replacement words, then an optional tail word.
	typedef struct packed {
		logic [1:0]      n_repl;
		logic            tail_v;
		logic [CP_W-1:0] tail_cp;
		logic            tail_rep;
	} plan_t;

endpackage

`default_nettype wire

@@ sv/utf8_decoder_with_replacement.sv @@
// Top level of the UTF-8 decoder with U+FFFD replacement.
// Depends on utf8d_pkg and utf8d_decode.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   byte in  | byte_valid, byte_stall| data_byte[7:0], end_of_stream
//   cp out   | cp_valid, cp_stall    | code_point[20:0], is_replacement, last_of_run
//
// One byte per cycle when each byte yields at most one word and cp_stall is low. A byte
// is registered in the input register, decoded from there, and its first word is then
// registered in the output register. A byte that yields more than one word stalls the
// input while the rest of the run drains from the output register.
// Reset clears the open sequence and all valid flags. cp_stall holds the output
// word and, once the pending run is empty, backs up into byte_stall.
`default_nettype none

module utf8_decoder_with_replacement (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_stream,
	output logic             cp_valid,
	input  wire logic        cp_stall,
	output logic [20:0]      code_point,
	output logic             is_replacement,
	output logic             last_of_run
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;

	utf8d_pkg::plan_t plan, cur, rem;

	logic [1:0]                 pend_repl_q;
	logic                       pend_tail_q;
	logic [utf8d_pkg::CP_W-1:0] tail_cp_q;
	logic                       tail_rep_q;

	logic                       out_valid_q;
	logic [utf8d_pkg::CP_W-1:0] code_point_q;
	logic                       is_repl_q;
	logic                       last_q;

	logic advance, pend_empty, plan_empty, take_s1, cur_has;
	logic [utf8d_pkg::CP_W-1:0] pop_cp;
	logic pop_rep, pop_last;

	utf8d_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte_s1 (byte_s1),
		.eos_s1       (eos_s1),
		.take         (take_s1),
		.plan         (plan)
	);

	assign advance    = !out_valid_q || !cp_stall;
	assign pend_empty = (pend_repl_q == 2'd0) && !pend_tail_q;
	assign plan_empty = (plan.n_repl == 2'd0) && !plan.tail_v;
	// a byte with no result may pass even while the output is stalled
	assign take_s1    = valid_s1 && pend_empty && (advance || plan_empty);
	assign byte_stall = valid_s1 && !take_s1;

	always_comb begin
		if (pend_empty) begin
			cur     = plan;
			cur_has = valid_s1 && !plan_empty;
		end else begin
			cur.n_repl   = pend_repl_q;
			cur.tail_v   = pend_tail_q;
			cur.tail_cp  = tail_cp_q;
			cur.tail_rep = tail_rep_q;
			cur_has      = 1'b1;
		end
		rem = cur;
		if (cur.n_repl != 2'd0) begin
			pop_cp     = utf8d_pkg::REPL_CP;
			pop_rep    = 1'b1;
			pop_last   = (cur.n_repl == 2'd1) && !cur.tail_v;
			rem.n_repl = cur.n_repl - 2'd1;
		end else begin
			pop_cp     = cur.tail_cp;
			pop_rep    = cur.tail_rep;
			pop_last   = 1'b1;
			rem.tail_v = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_repl_q <= 2'd0;
			pend_tail_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cur_has;
			if (cur_has) begin
				pend_repl_q <= rem.n_repl;
				pend_tail_q <= rem.tail_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cur_has) begin
			code_point_q <= pop_cp;
			is_repl_q    <= pop_rep;
			last_q       <= pop_last;
			tail_cp_q    <= rem.tail_cp;
			tail_rep_q   <= rem.tail_rep;
		end
	end

	assign cp_valid       = out_valid_q;
	assign code_point     = code_point_q;
	assign is_replacement = is_repl_q;
	assign last_of_run    = last_q;

endmodule

`default_nettype wire

@@ sv/utf8d_decode.sv @@
// Sequence state and per-byte decode for the UTF-8 decoder.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_decode (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [7:0]              data_byte_s1,
	input  wire logic                    eos_s1,
	input  wire logic                    take,
	output utf8d_pkg::plan_t             plan
);

	logic [utf8d_pkg::CP_W-1:0] pv_q, pv_d;
	logic [2:0]                 len_q, len_d;
	logic [1:0]                 cc_q, cc_d;

	logic                       seq_open, is_cont, complete, bad;
	logic [2:0]                 cnt;
	logic [utf8d_pkg::CP_W-1:0] pv_new, minv;
	logic [2:0]                 lead_len;
	logic [utf8d_pkg::CP_W-1:0] lead_pv;

	assign seq_open = (len_q != utf8d_pkg::LEN_NONE);
	assign is_cont  = (data_byte_s1[7:6] == 2'b10);
	assign cnt      = {1'b0, cc_q} + 3'd1;
	assign pv_new   = {pv_q[utf8d_pkg::CP_W-7:0], data_byte_s1[5:0]};
	assign complete = (cnt == len_q);

	always_comb begin
		unique case (len_q)
			utf8d_pkg::LEN_2: minv = utf8d_pkg::MIN_LEN2;
			utf8d_pkg::LEN_3: minv = utf8d_pkg::MIN_LEN3;
			default:          minv = utf8d_pkg::MIN_LEN4;
		endcase
	end

	assign bad = (pv_new < minv)
		|| (pv_new >= utf8d_pkg::SURR_LO && pv_new <= utf8d_pkg::SURR_HI)
		|| (pv_new > utf8d_pkg::MAX_SCALAR);

	// Classify the byte as a lead.
	always_comb begin
		priority if (data_byte_s1[7:5] == 3'b110) begin
			lead_len = utf8d_pkg::LEN_2;
			lead_pv  = {16'd0, data_byte_s1[4:0]};
		end else if (data_byte_s1[7:4] == 4'b1110) begin
			lead_len = utf8d_pkg::LEN_3;
			lead_pv  = {17'd0, data_byte_s1[3:0]};
		end else if (data_byte_s1[7:3] == 5'b11110) begin
			lead_len = utf8d_pkg::LEN_4;
			lead_pv  = {18'd0, data_byte_s1[2:0]};
		end else begin
			lead_len = utf8d_pkg::LEN_NONE;
			lead_pv  = '0;
		end
	end

	always_comb begin
		plan.n_repl   = 2'd0;
		plan.tail_v   = 1'b0;
		plan.tail_cp  = utf8d_pkg::REPL_CP;
		plan.tail_rep = 1'b1;
		pv_d  = '0;
		len_d = utf8d_pkg::LEN_NONE;
		cc_d  = 2'd0;
		if (seq_open && is_cont) begin
			if (complete) begin
				plan.tail_v   = 1'b1;
				plan.tail_cp  = bad ? utf8d_pkg::REPL_CP : pv_new;
				plan.tail_rep = bad;
			end else if (eos_s1) begin
				// truncated at end: one replacement per held byte and one for this byte
				plan.n_repl = cnt[1:0];
			end else begin
				pv_d  = pv_new;
				len_d = len_q;
				cc_d  = cnt[1:0];
			end
		end else begin
			// broken sequence: flush held bytes, then treat this byte as a lead
			plan.n_repl = seq_open ? cc_q : 2'd0;
			if (!data_byte_s1[7]) begin
				plan.tail_v   = 1'b1;
				plan.tail_cp  = {13'd0, data_byte_s1};
				plan.tail_rep = 1'b0;
			end else if (lead_len == utf8d_pkg::LEN_NONE || eos_s1) begin
				plan.tail_v = 1'b1;
			end else begin
				pv_d  = lead_pv;
				len_d = lead_len;
				cc_d  = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= '0;
			len_q <= utf8d_pkg::LEN_NONE;
			cc_q  <= 2'd0;
		end else if (take) begin
			pv_q  <= pv_d;
			len_q <= len_d;
			cc_q  <= cc_d;
		end
	end

endmodule

`default_nettype wire
